>>> rtl/ppas_pkg.sv
`default_nettype none

package ppas_pkg;

    // Configuration port geometry
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address is four times the index)
    localparam logic [1:0] REG_SHOULDER_MIN = 2'd0;
    localparam logic [1:0] REG_SHOULDER_MAX = 2'd1;
    localparam logic [1:0] REG_CLAW_CLOSED  = 2'd2;

    // Request opcodes
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_ABORT  = 2'd2;
    localparam logic [1:0] OP_RESET  = 2'd3;

    // Command kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SIX    = 2'd1;
    localparam logic [1:0] KIND_SINGLE = 2'd2;
    localparam logic [1:0] KIND_ESTOP  = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_BUSY    = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT = 2'd2;

    // Servo channels for single moves
    localparam logic [2:0] CH_WRIST_PITCH = 3'd4;
    localparam logic [2:0] CH_CLAW        = 3'd5;

    // Timing limits in milliseconds
    localparam int STALL_MS     = 10000;
    localparam int GRIP_WAIT_MS = 1000;
    localparam int OPEN_WAIT_MS = 800;
    localparam int SETTLE_MS    = 600;

    // Fixed angles
    localparam logic [7:0] GRIP_ANGLE  = 8'd88;
    localparam logic [7:0] OPEN_ANGLE  = 8'd30;
    localparam logic [7:0] PITCH_PLACE = 8'd160;

    // Shoulder bases that take the height offset
    localparam logic signed [9:0] SH_APPROACH  = 10'sd35;
    localparam logic signed [9:0] SH_DOWN      = 10'sd22;
    localparam logic signed [9:0] SH_LIFT      = 10'sd45;
    localparam logic signed [9:0] SH_BACK_APP  = 10'sd145;
    localparam logic signed [9:0] SH_PLACE     = 10'sd158;

    // Phase codes as seen on the result channel
    localparam logic [4:0] PC_IDLE       = 5'd0;
    localparam logic [4:0] PC_CALC       = 5'd1;
    localparam logic [4:0] PC_START      = 5'd2;
    localparam logic [4:0] PC_APPROACH   = 5'd3;
    localparam logic [4:0] PC_DOWN       = 5'd4;
    localparam logic [4:0] PC_CLOSE      = 5'd5;
    localparam logic [4:0] PC_WAIT_CLOSE = 5'd6;
    localparam logic [4:0] PC_LIFT       = 5'd7;
    localparam logic [4:0] PC_TRANSIT    = 5'd8;
    localparam logic [4:0] PC_BACK_APP   = 5'd9;
    localparam logic [4:0] PC_PLACE      = 5'd10;
    localparam logic [4:0] PC_PITCH      = 5'd11;
    localparam logic [4:0] PC_RELEASE    = 5'd12;
    localparam logic [4:0] PC_WAIT_REL   = 5'd13;
    localparam logic [4:0] PC_RETREAT    = 5'd14;
    localparam logic [4:0] PC_HOME       = 5'd15;
    localparam logic [4:0] PC_DONE       = 5'd16;
    localparam logic [4:0] PC_ABORTED    = 5'd17;

    // Sequencer phase, one-hot
    typedef enum logic [17:0] {
        PH_IDLE       = 18'h00001,
        PH_CALC       = 18'h00002,
        PH_START      = 18'h00004,
        PH_APPROACH   = 18'h00008,
        PH_DOWN       = 18'h00010,
        PH_CLOSE      = 18'h00020,
        PH_WAIT_CLOSE = 18'h00040,
        PH_LIFT       = 18'h00080,
        PH_TRANSIT    = 18'h00100,
        PH_BACK_APP   = 18'h00200,
        PH_PLACE      = 18'h00400,
        PH_PITCH      = 18'h00800,
        PH_RELEASE    = 18'h01000,
        PH_WAIT_REL   = 18'h02000,
        PH_RETREAT    = 18'h04000,
        PH_HOME       = 18'h08000,
        PH_DONE       = 18'h10000,
        PH_ABORTED    = 18'h20000
    } ppas_phase_t;

    typedef struct packed {
        logic [7:0] shoulder_min;
        logic [7:0] shoulder_max;
        logic [7:0] claw_closed_angle;
    } ppas_cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic        servos_moving;
        logic [9:0]  obj_height;
    } ppas_req_t;

    typedef struct packed {
        logic       accepted;
        logic [1:0] command_kind;
        logic [2:0] channel;
        logic [7:0] single_angle;
        logic [7:0] waist_angle;
        logic [7:0] shoulder_angle;
        logic [7:0] elbow_angle;
        logic [7:0] wrist_roll_angle;
        logic [7:0] wrist_pitch_angle;
        logic [7:0] claw_angle;
        logic [4:0] phase_out;
        logic [1:0] error_code;
    } ppas_res_t;

    // Binary code of a one-hot phase
    function automatic logic [4:0] phase_code(input ppas_phase_t ph);
        logic [4:0] c;
        begin
            unique case (ph)
                PH_IDLE:       c = PC_IDLE;
                PH_CALC:       c = PC_CALC;
                PH_START:      c = PC_START;
                PH_APPROACH:   c = PC_APPROACH;
                PH_DOWN:       c = PC_DOWN;
                PH_CLOSE:      c = PC_CLOSE;
                PH_WAIT_CLOSE: c = PC_WAIT_CLOSE;
                PH_LIFT:       c = PC_LIFT;
                PH_TRANSIT:    c = PC_TRANSIT;
                PH_BACK_APP:   c = PC_BACK_APP;
                PH_PLACE:      c = PC_PLACE;
                PH_PITCH:      c = PC_PITCH;
                PH_RELEASE:    c = PC_RELEASE;
                PH_WAIT_REL:   c = PC_WAIT_REL;
                PH_RETREAT:    c = PC_RETREAT;
                PH_HOME:       c = PC_HOME;
                PH_DONE:       c = PC_DONE;
                PH_ABORTED:    c = PC_ABORTED;
                default:       c = PC_IDLE;
            endcase
            return c;
        end
    endfunction

    // Height offset: height saturated to 5..125, (h - 50) / 5 toward zero,
    // limited to 15. The divide by five is a multiply by 205/1024, exact
    // for magnitudes up to 74.
    function automatic logic signed [4:0] height_offset(input logic [9:0] h);
        logic [7:0]        hc;
        logic signed [8:0] x;
        logic [6:0]        mag;
        logic [14:0]       prod;
        logic [4:0]        q;
        logic signed [4:0] d;
        begin
            if (h < 10'd5) begin
                hc = 8'd5;
            end else if (h > 10'd124) begin
                hc = 8'd125;
            end else begin
                hc = h[7:0];
            end
            x    = $signed({1'b0, hc}) - 9'sd50;
            mag  = x[8] ? 7'(-x) : x[6:0];
            prod = 15'(mag) * 15'd205;
            q    = prod[14:10];
            if (hc >= 8'd125) begin
                d = 5'sd15;
            end else if (x[8]) begin
                d = -$signed(q);
            end else begin
                d = $signed(q);
            end
            return d;
        end
    endfunction

    // Shoulder clamp; the low bound wins when the bounds cross
    function automatic logic [7:0] clamp_shoulder(input logic signed [9:0] v,
                                                  input logic [7:0] lo,
                                                  input logic [7:0] hi);
        logic [7:0] r;
        begin
            if (v < $signed({2'b00, lo})) begin
                r = lo;
            end else if (v > $signed({2'b00, hi})) begin
                r = hi;
            end else begin
                r = v[7:0];
            end
            return r;
        end
    endfunction

    function automatic ppas_res_t six_move(input logic [7:0] w, input logic [7:0] s,
                                           input logic [7:0] e, input logic [7:0] r,
                                           input logic [7:0] p, input logic [7:0] c);
        ppas_res_t o;
        begin
            o                   = '0;
            o.command_kind      = KIND_SIX;
            o.waist_angle       = w;
            o.shoulder_angle    = s;
            o.elbow_angle       = e;
            o.wrist_roll_angle  = r;
            o.wrist_pitch_angle = p;
            o.claw_angle        = c;
            return o;
        end
    endfunction

    function automatic ppas_res_t single_move(input logic [2:0] ch, input logic [7:0] a);
        ppas_res_t o;
        begin
            o              = '0;
            o.command_kind = KIND_SINGLE;
            o.channel      = ch;
            o.single_angle = a;
            return o;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/pick_place_arm_sequencer.sv
`default_nettype none

// Pick-and-place arm sequencer. Each request on the s_ channel (update,
// start pick, abort or reset to idle) yields exactly one result on the m_
// channel: a six-angle move, a single-channel move, an emergency stop or no
// command, together with the phase after the step and the last error. The
// block takes one request per clock cycle while the result side is not
// stalled; an accepted request is held in the input register until the
// output register is free or being drained; its result is then loaded into
// the output register and offered on the m_ channel. Requests are held
// off only while both registers are full and the result side is stalled. The
// sequencer state (phase, phase start time, height offset, last error) is
// updated by one pass of logic between those registers. Shoulder limits and
// the home claw angle are set over the APB port at byte addresses 0, 4 and 8
// and should be written while no request is in flight. TIME_BITS sets the
// width in which elapsed time is taken; now_ms is truncated or zero-extended
// to it.
module pick_place_arm_sequencer #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Request channel
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [31:0] now_ms, [32] servos_moving, [42:33] obj_height
    input  wire logic [47:0]                        s_tdata,
    // [1:0] opcode
    input  wire logic [1:0]                         s_tuser,
    // Result channel
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [0] accepted, [3:1] channel, [11:4] single_angle, [19:12] waist_angle,
    // [27:20] shoulder_angle, [35:28] elbow_angle, [43:36] wrist_roll_angle,
    // [51:44] wrist_pitch_angle, [59:52] claw_angle, [64:60] phase_out,
    // [66:65] error_code
    output logic [71:0]                             m_tdata,
    // [1:0] command_kind
    output logic [1:0]                              m_tuser,
    // Configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ppas_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [ppas_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [ppas_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready
);
    import ppas_pkg::*;

    ppas_cfg_t  cfg;
    ppas_req_t  req_reg;
    logic       req_valid_reg;
    ppas_res_t  res_reg;
    ppas_res_t  res;
    logic       m_valid_reg;
    logic       out_free;
    logic       fire;

    ppas_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Flow control: the input register moves on whenever the output
    // register is empty or being drained.
    assign out_free = !m_valid_reg || m_tready;
    assign fire     = req_valid_reg && out_free;
    assign s_tready = !req_valid_reg || out_free;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            req_valid_reg <= 1'b1;
        end else if (fire) begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg.opcode        <= s_tuser;
            req_reg.now_ms        <= s_tdata[31:0];
            req_reg.servos_moving <= s_tdata[32];
            req_reg.obj_height    <= s_tdata[42:33];
        end
    end

    ppas_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .req     (req_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.command_kind;
    assign m_tdata  = {5'd0,
                       res_reg.error_code,
                       res_reg.phase_out,
                       res_reg.claw_angle,
                       res_reg.wrist_pitch_angle,
                       res_reg.wrist_roll_angle,
                       res_reg.elbow_angle,
                       res_reg.shoulder_angle,
                       res_reg.waist_angle,
                       res_reg.single_angle,
                       res_reg.channel,
                       res_reg.accepted};

    // Back pressure on requests only when both registers are occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> req_valid_reg && m_valid_reg)
        else $error("request stalled with a free register");

    // Every processed request shows up as a result on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("processed request produced no result");

    // A held result is never overwritten by a new request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !fire)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> rtl/ppas_apb_regs.sv
`default_nettype none

module ppas_apb_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ppas_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [ppas_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [ppas_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready,
    output ppas_pkg::ppas_cfg_t                     cfg
);
    import ppas_pkg::*;

    logic [7:0] shoulder_min_reg;
    logic [7:0] shoulder_max_reg;
    logic [7:0] claw_closed_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes on the access cycle of a write request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shoulder_min_reg <= 8'd0;
            shoulder_max_reg <= 8'd180;
            claw_closed_reg  <= 8'd90;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_SHOULDER_MIN: shoulder_min_reg <= pwdata[7:0];
                REG_SHOULDER_MAX: shoulder_max_reg <= pwdata[7:0];
                REG_CLAW_CLOSED:  claw_closed_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux; addresses past the register list read as zero.
    always_comb begin
        unique case (paddr[3:2])
            REG_SHOULDER_MIN: prdata = {24'd0, shoulder_min_reg};
            REG_SHOULDER_MAX: prdata = {24'd0, shoulder_max_reg};
            REG_CLAW_CLOSED:  prdata = {24'd0, claw_closed_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.shoulder_min      = shoulder_min_reg;
    assign cfg.shoulder_max      = shoulder_max_reg;
    assign cfg.claw_closed_angle = claw_closed_reg;

endmodule

`default_nettype wire

>>> rtl/ppas_step.sv
`default_nettype none

module ppas_step #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                fire,
    input  wire ppas_pkg::ppas_req_t req,
    input  wire ppas_pkg::ppas_cfg_t cfg,
    output ppas_pkg::ppas_res_t      res
);
    import ppas_pkg::*;

    ppas_phase_t           phase_reg, phase_next;
    logic [TIME_BITS-1:0]  start_time_reg, start_time_next;
    logic signed [4:0]     offset_reg, offset_next;
    logic [1:0]            error_reg, error_next;

    logic [TIME_BITS-1:0]  now_t;
    logic [TIME_BITS-1:0]  elapsed;
    logic signed [9:0]     d;
    logic                  parked;
    logic                  moving;
    ppas_res_t             cmd;

    assign now_t   = TIME_BITS'(req.now_ms);
    assign elapsed = now_t - start_time_reg;
    assign d       = 10'(offset_reg);
    assign moving  = req.servos_moving;
    assign parked  = (phase_reg == PH_IDLE) || (phase_reg == PH_DONE) ||
                     (phase_reg == PH_ABORTED);

    // One step of the sequencer for the request at hand.
    always_comb begin
        phase_next      = phase_reg;
        start_time_next = start_time_reg;
        offset_next     = offset_reg;
        error_next      = error_reg;
        cmd             = '0;

        unique case (req.opcode)
            OP_UPDATE: begin
                if (parked) begin
                    cmd = '0;
                end else if (!moving && phase_reg != PH_RELEASE &&
                             elapsed > TIME_BITS'(STALL_MS)) begin
                    // Stalled with idle servos: give up.
                    error_next = ERR_TIMEOUT;
                    phase_next = PH_ABORTED;
                end else begin
                    unique case (phase_reg)
                        PH_CALC: begin
                            phase_next      = PH_START;
                            start_time_next = now_t;
                        end
                        PH_START: begin
                            cmd             = single_move(CH_CLAW, OPEN_ANGLE);
                            phase_next      = PH_APPROACH;
                            start_time_next = now_t;
                        end
                        PH_APPROACH: begin
                            if (!moving) begin
                                cmd = six_move(8'd45, clamp_shoulder(SH_APPROACH + d,
                                               cfg.shoulder_min, cfg.shoulder_max),
                                               8'd90, 8'd90, 8'd30, OPEN_ANGLE);
                                phase_next      = PH_DOWN;
                                start_time_next = now_t;
                            end
                        end
                        PH_DOWN: begin
                            if (!moving) begin
                                cmd = six_move(8'd45, clamp_shoulder(SH_DOWN + d,
                                               cfg.shoulder_min, cfg.shoulder_max),
                                               8'd101, 8'd90, 8'd30, OPEN_ANGLE);
                                phase_next      = PH_CLOSE;
                                start_time_next = now_t;
                            end
                        end
                        PH_CLOSE: begin
                            if (!moving) begin
                                cmd             = single_move(CH_CLAW, GRIP_ANGLE);
                                phase_next      = PH_WAIT_CLOSE;
                                start_time_next = now_t;
                            end
                        end
                        PH_WAIT_CLOSE: begin
                            if (elapsed > TIME_BITS'(GRIP_WAIT_MS)) begin
                                phase_next      = PH_LIFT;
                                start_time_next = now_t;
                            end
                        end
                        PH_LIFT: begin
                            if (!moving) begin
                                cmd = six_move(8'd45, clamp_shoulder(SH_LIFT + d,
                                               cfg.shoulder_min, cfg.shoulder_max),
                                               8'd85, 8'd90, 8'd30, GRIP_ANGLE);
                                phase_next      = PH_TRANSIT;
                                start_time_next = now_t;
                            end
                        end
                        PH_TRANSIT: begin
                            if (!moving) begin
                                cmd = six_move(8'd90, 8'd90, 8'd80, 8'd90, 8'd30,
                                               GRIP_ANGLE);
                                phase_next      = PH_BACK_APP;
                                start_time_next = now_t;
                            end
                        end
                        PH_BACK_APP: begin
                            if (!moving) begin
                                cmd = six_move(8'd135, clamp_shoulder(SH_BACK_APP - d,
                                               cfg.shoulder_min, cfg.shoulder_max),
                                               8'd95, 8'd90, 8'd30, GRIP_ANGLE);
                                phase_next      = PH_PLACE;
                                start_time_next = now_t;
                            end
                        end
                        PH_PLACE: begin
                            if (!moving) begin
                                cmd = six_move(8'd135, clamp_shoulder(SH_PLACE - d,
                                               cfg.shoulder_min, cfg.shoulder_max),
                                               8'd90, 8'd90, 8'd30, GRIP_ANGLE);
                                phase_next      = PH_PITCH;
                                start_time_next = now_t;
                            end
                        end
                        PH_PITCH: begin
                            if (!moving && !(elapsed < TIME_BITS'(SETTLE_MS))) begin
                                cmd             = single_move(CH_WRIST_PITCH, PITCH_PLACE);
                                phase_next      = PH_RELEASE;
                                start_time_next = now_t;
                            end
                        end
                        PH_RELEASE: begin
                            if (!moving) begin
                                cmd             = single_move(CH_CLAW, OPEN_ANGLE);
                                phase_next      = PH_WAIT_REL;
                                start_time_next = now_t;
                            end
                        end
                        PH_WAIT_REL: begin
                            if (elapsed > TIME_BITS'(OPEN_WAIT_MS)) begin
                                phase_next      = PH_RETREAT;
                                start_time_next = now_t;
                            end
                        end
                        PH_RETREAT: begin
                            if (!moving) begin
                                cmd = six_move(8'd135, 8'd145, 8'd85, 8'd90, 8'd150,
                                               OPEN_ANGLE);
                                phase_next      = PH_HOME;
                                start_time_next = now_t;
                            end
                        end
                        PH_HOME: begin
                            if (!moving) begin
                                cmd = six_move(8'd90, 8'd90, 8'd90, 8'd90, 8'd90,
                                               cfg.claw_closed_angle);
                                phase_next = PH_DONE;
                            end
                        end
                        default: begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            OP_START: begin
                if (!parked) begin
                    error_next = ERR_BUSY;
                end else begin
                    offset_next     = height_offset(req.obj_height);
                    phase_next      = PH_CALC;
                    start_time_next = now_t;
                    cmd.accepted    = 1'b1;
                end
            end
            OP_ABORT: begin
                if (phase_reg != PH_IDLE && phase_reg != PH_DONE) begin
                    phase_next       = PH_ABORTED;
                    cmd.command_kind = KIND_ESTOP;
                end
            end
            OP_RESET: begin
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        res            = cmd;
        res.phase_out  = phase_code(phase_next);
        res.error_code = error_next;
    end

    // Sequencer state advances once per request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            start_time_reg <= '0;
            offset_reg     <= '0;
            error_reg      <= ERR_NONE;
        end else if (fire) begin
            phase_reg      <= phase_next;
            start_time_reg <= start_time_next;
            offset_reg     <= offset_next;
            error_reg      <= error_next;
        end
    end

    // A pick that begins always lands in pose calculation with no move.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.accepted |-> res.command_kind == KIND_NONE &&
                                 res.phase_out == PC_CALC)
        else $error("accepted start did not enter pose calculation");

    // An emergency stop leaves the sequencer aborted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.command_kind == KIND_ESTOP |=> phase_reg == PH_ABORTED)
        else $error("emergency stop without aborted phase");

    // Single moves only ever drive the wrist pitch or the claw.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.command_kind == KIND_SINGLE |->
            res.channel == CH_WRIST_PITCH || res.channel == CH_CLAW)
        else $error("single move on an unexpected channel");

endmodule

`default_nettype wire

>>> sim/arm_sequence_checker.sv
`timescale 1ns / 100ps

// Watches both streams and the register port of the arm sequencer. It keeps its
// own copy of the phase machine, predicts one result per accepted request and
// compares every accepted result, field by field, with the oldest prediction.
module arm_sequence_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [47:0]                     s_tdata,
    input  wire logic [1:0]                      s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [71:0]                     m_tdata,
    input  wire logic [1:0]                      m_tuser,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [ppas_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [ppas_pkg::APB_DATA_W-1:0] pwdata,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   checked,
    output int                                   finished_picks
);
    import ppas_pkg::*;

    // Timing limits in milliseconds and fixed claw angles of the routine
    localparam logic [31:0] STALL_LIMIT = 32'd10000;
    localparam logic [31:0] GRIP_WAIT   = 32'd1000;
    localparam logic [31:0] OPEN_WAIT   = 32'd800;
    localparam logic [31:0] SETTLE_WAIT = 32'd600;
    localparam int          CLAW_GRIP   = 88;
    localparam int          CLAW_OPEN   = 30;

    ppas_res_t   arm_results_q[$];
    ppas_res_t   want;
    ppas_res_t   got;

    // Predicted sequencer state and register copies
    logic [7:0]  shoulder_lo;
    logic [7:0]  shoulder_hi;
    logic [7:0]  home_claw;
    logic [4:0]  arm_phase;
    logic [31:0] phase_began;
    int          height_shift;
    logic [1:0]  sticky_error;

    function automatic logic [7:0] shoulder_fit(input int v);
        // The lower limit is tested first, so it wins when the limits cross.
        if (v < int'(shoulder_lo)) begin
            return shoulder_lo;
        end
        if (v > int'(shoulder_hi)) begin
            return shoulder_hi;
        end
        return 8'(v);
    endfunction

    function automatic ppas_res_t pose(input int w, input int s, input int e,
                                       input int r, input int p, input int c);
        ppas_res_t o;
        o                   = '0;
        o.command_kind      = KIND_SIX;
        o.waist_angle       = 8'(w);
        o.shoulder_angle    = 8'(s);
        o.elbow_angle       = 8'(e);
        o.wrist_roll_angle  = 8'(r);
        o.wrist_pitch_angle = 8'(p);
        o.claw_angle        = 8'(c);
        return o;
    endfunction

    function automatic ppas_res_t servo_move(input logic [2:0] ch, input int a);
        ppas_res_t o;
        o              = '0;
        o.command_kind = KIND_SINGLE;
        o.channel      = ch;
        o.single_angle = 8'(a);
        return o;
    endfunction

    function automatic void enter(input logic [4:0] next, input logic [31:0] now);
        arm_phase   = next;
        phase_began = now;
    endfunction

    // One update request: stall check, then the phase-specific move.
    function automatic ppas_res_t advance(input logic [31:0] now, input logic moving);
        ppas_res_t   o;
        logic [31:0] elapsed;
        o       = '0;
        elapsed = now - phase_began;
        if (arm_phase == PC_IDLE || arm_phase == PC_DONE || arm_phase == PC_ABORTED) begin
            return o;
        end
        if (!moving && arm_phase != PC_RELEASE && elapsed > STALL_LIMIT) begin
            sticky_error = ERR_TIMEOUT;
            arm_phase    = PC_ABORTED;
            return o;
        end
        case (arm_phase)
            PC_CALC: begin
                enter(PC_START, now);
            end
            PC_START: begin
                o = servo_move(CH_CLAW, CLAW_OPEN);
                enter(PC_APPROACH, now);
            end
            PC_APPROACH: if (!moving) begin
                o = pose(45, shoulder_fit(35 + height_shift), 90, 90, 30, CLAW_OPEN);
                enter(PC_DOWN, now);
            end
            PC_DOWN: if (!moving) begin
                o = pose(45, shoulder_fit(22 + height_shift), 101, 90, 30, CLAW_OPEN);
                enter(PC_CLOSE, now);
            end
            PC_CLOSE: if (!moving) begin
                o = servo_move(CH_CLAW, CLAW_GRIP);
                enter(PC_WAIT_CLOSE, now);
            end
            PC_WAIT_CLOSE: if (elapsed > GRIP_WAIT) begin
                enter(PC_LIFT, now);
            end
            PC_LIFT: if (!moving) begin
                o = pose(45, shoulder_fit(45 + height_shift), 85, 90, 30, CLAW_GRIP);
                enter(PC_TRANSIT, now);
            end
            PC_TRANSIT: if (!moving) begin
                o = pose(90, 90, 80, 90, 30, CLAW_GRIP);
                enter(PC_BACK_APP, now);
            end
            PC_BACK_APP: if (!moving) begin
                o = pose(135, shoulder_fit(145 - height_shift), 95, 90, 30, CLAW_GRIP);
                enter(PC_PLACE, now);
            end
            PC_PLACE: if (!moving) begin
                o = pose(135, shoulder_fit(158 - height_shift), 90, 90, 30, CLAW_GRIP);
                enter(PC_PITCH, now);
            end
            PC_PITCH: if (!moving && elapsed >= SETTLE_WAIT) begin
                o = servo_move(CH_WRIST_PITCH, 160);
                enter(PC_RELEASE, now);
            end
            PC_RELEASE: if (!moving) begin
                o = servo_move(CH_CLAW, CLAW_OPEN);
                enter(PC_WAIT_REL, now);
            end
            PC_WAIT_REL: if (elapsed > OPEN_WAIT) begin
                enter(PC_RETREAT, now);
            end
            PC_RETREAT: if (!moving) begin
                o = pose(135, 145, 85, 90, 150, CLAW_OPEN);
                enter(PC_HOME, now);
            end
            PC_HOME: if (!moving) begin
                // The home pose keeps the start time of the previous phase.
                o         = pose(90, 90, 90, 90, 90, home_claw);
                arm_phase = PC_DONE;
                finished_picks++;
            end
            default: begin
            end
        endcase
        return o;
    endfunction

    // Full result of one request, including phase and error after the step.
    function automatic ppas_res_t step_sequencer(input logic [1:0] op,
                                                 input logic [31:0] now,
                                                 input logic moving,
                                                 input logic [9:0] h);
        ppas_res_t o;
        int        hc;
        o = '0;
        case (op)
            OP_UPDATE: begin
                o = advance(now, moving);
            end
            OP_START: begin
                if (arm_phase != PC_IDLE && arm_phase != PC_DONE &&
                    arm_phase != PC_ABORTED) begin
                    sticky_error = ERR_BUSY;
                end else begin
                    // Height saturates to 5..200; the offset divides toward zero.
                    hc           = (h < 10'd5) ? 5 : (h > 10'd200) ? 200 : int'(h);
                    height_shift = (hc - 50) / 5;
                    if (height_shift > 15) begin
                        height_shift = 15;
                    end
                    enter(PC_CALC, now);
                    o.accepted = 1'b1;
                end
            end
            OP_ABORT: begin
                if (arm_phase != PC_IDLE && arm_phase != PC_DONE) begin
                    arm_phase      = PC_ABORTED;
                    o.command_kind = KIND_ESTOP;
                end
            end
            default: begin
                arm_phase = PC_IDLE;
            end
        endcase
        o.phase_out  = arm_phase;
        o.error_code = sticky_error;
        return o;
    endfunction

    task automatic compare(input string what, input int unsigned exp_v,
                           input int unsigned act_v);
        if (exp_v != act_v) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, what, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            shoulder_lo    = 8'd0;
            shoulder_hi    = 8'd180;
            home_claw      = 8'd90;
            arm_phase      = PC_IDLE;
            phase_began    = '0;
            height_shift   = 0;
            sticky_error   = ERR_NONE;
            fail_count     = 0;
            checked        = 0;
            finished_picks = 0;
            arm_results_q.delete();
        end else begin
            // Register writes land at the access cycle.
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SHOULDER_MIN: shoulder_lo = pwdata[7:0];
                    REG_SHOULDER_MAX: shoulder_hi = pwdata[7:0];
                    REG_CLAW_CLOSED:  home_claw   = pwdata[7:0];
                    default: begin
                    end
                endcase
            end

            // Accepted result against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.accepted          = m_tdata[0];
                got.channel           = m_tdata[3:1];
                got.single_angle      = m_tdata[11:4];
                got.waist_angle       = m_tdata[19:12];
                got.shoulder_angle    = m_tdata[27:20];
                got.elbow_angle       = m_tdata[35:28];
                got.wrist_roll_angle  = m_tdata[43:36];
                got.wrist_pitch_angle = m_tdata[51:44];
                got.claw_angle        = m_tdata[59:52];
                got.phase_out         = m_tdata[64:60];
                got.error_code        = m_tdata[66:65];
                got.command_kind      = m_tuser;
                if (arm_results_q.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result with no request waiting, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    want = arm_results_q.pop_front();
                    compare("accepted", want.accepted, got.accepted);
                    compare("command_kind", want.command_kind, got.command_kind);
                    compare("channel", want.channel, got.channel);
                    compare("single_angle", want.single_angle, got.single_angle);
                    compare("waist_angle", want.waist_angle, got.waist_angle);
                    compare("shoulder_angle", want.shoulder_angle, got.shoulder_angle);
                    compare("elbow_angle", want.elbow_angle, got.elbow_angle);
                    compare("wrist_roll_angle", want.wrist_roll_angle,
                            got.wrist_roll_angle);
                    compare("wrist_pitch_angle", want.wrist_pitch_angle,
                            got.wrist_pitch_angle);
                    compare("claw_angle", want.claw_angle, got.claw_angle);
                    compare("phase_out", want.phase_out, got.phase_out);
                    compare("error_code", want.error_code, got.error_code);
                    checked++;
                end
            end

            // Accepted request: predict its result
            if (s_tvalid && s_tready) begin
                arm_results_q.push_back(step_sequencer(s_tuser, s_tdata[31:0],
                                                       s_tdata[32], s_tdata[42:33]));
            end
        end
        pending = arm_results_q.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ppas_pkg::*;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [31:0] now_ms, [32] servos_moving, [42:33] obj_height
    logic [47:0]           s_tdata  = '0;
    // [1:0] opcode
    logic [1:0]            s_tuser  = OP_UPDATE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] accepted, [3:1] channel, [11:4] single_angle, [19:12] waist_angle,
    // [27:20] shoulder_angle, [35:28] elbow_angle, [43:36] wrist_roll_angle,
    // [51:44] wrist_pitch_angle, [59:52] claw_angle, [64:60] phase_out,
    // [66:65] error_code
    logic [71:0]           m_tdata;
    // [1:0] command_kind
    logic [1:0]            m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int checked;
    int finished_picks;
    int sent       = 0;
    int n_settings = 0;
    bit calm       = 1'b0;
    bit long_hold  = 1'b0;

    // Register settings of the first phases; the later ones are random.
    logic [7:0] lo_table   [6] = '{8'd0, 8'd40, 8'd180, 8'd0, 8'd180, 8'd100};
    logic [7:0] hi_table   [6] = '{8'd180, 8'd140, 8'd0, 8'd0, 8'd180, 8'd60};
    logic [7:0] claw_table [6] = '{8'd90, 8'd0, 8'd180, 8'd45, 8'd135, 8'd30};
    // Heights around the saturation and rounding points of the offset
    logic [9:0] edge_heights [11] = '{10'd0, 10'd4, 10'd5, 10'd44, 10'd49, 10'd50,
                                      10'd124, 10'd125, 10'd200, 10'd201, 10'd1023};

    pick_place_arm_sequencer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    arm_sequence_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked),
        .finished_picks (finished_picks)
    );

    always #6 aclk = ~aclk;

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Offer one request and wait until it is taken; then maybe pause.
    task automatic send_req(input logic [1:0] op, input logic [31:0] now,
                            input logic moving, input logic [9:0] h);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, h, moving, now};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every predicted result has arrived.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Setup phase, then access phase, then the bus goes quiet.
    task automatic reg_write(input logic [1:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // A pick with random content: mostly updates with small time steps so
    // that the routine gets far, with rare stalls, aborts, resets and restarts.
    task automatic pick_routine();
        logic [31:0] t;
        logic [1:0]  op;
        logic [9:0]  h;
        int          r;
        t = $urandom();
        if ($urandom_range(0, 1) == 0) begin
            send_req(OP_RESET, t, 1'($urandom()), 10'($urandom()));
        end
        h = ($urandom_range(0, 9) < 3) ? edge_heights[$urandom_range(0, 10)]
                                       : 10'($urandom());
        send_req(OP_START, t, 1'($urandom()), h);
        repeat ($urandom_range(20, 40)) begin
            r = $urandom_range(0, 99);
            t = t + ((r < 3) ? $urandom_range(9000, 12000) : $urandom_range(0, 1300));
            r = $urandom_range(0, 99);
            op = (r < 2) ? OP_ABORT : (r < 4) ? OP_RESET : (r < 7) ? OP_START : OP_UPDATE;
            send_req(op, t, $urandom_range(0, 99) < 25, 10'($urandom()));
        end
    endtask

    // Result side: short random stalls, one long hold-off on request.
    initial begin
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (64) @(posedge aclk);
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
    end

    // Request side and verdict
    initial begin
        logic [31:0] t;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  claw;
        int          target;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        for (int k = 0; k < 8; k++) begin
            settle();
            if (k < 6) begin
                lo   = lo_table[k];
                hi   = hi_table[k];
                claw = claw_table[k];
            end else begin
                lo   = 8'($urandom_range(0, 180));
                hi   = 8'($urandom_range(0, 180));
                claw = 8'($urandom_range(0, 180));
            end
            reg_write(REG_SHOULDER_MIN, lo);
            reg_write(REG_SHOULDER_MAX, hi);
            reg_write(REG_CLAW_CLOSED, claw);
            n_settings++;
            if (k == 7) begin
                calm = 1'b1;
            end
            if (k == 2) begin
                long_hold = 1'b1;
            end
            if (k == 0) begin
                // Directed opening: idle commands, busy start, wrapping time,
                // stall timeout, repeated abort, reset keeping the error.
                t = 32'hFFFF_FF00;
                send_req(OP_UPDATE, t, 1'b0, 10'd0);
                send_req(OP_ABORT, t, 1'b1, 10'h3FF);
                send_req(OP_START, t, 1'b0, 10'd0);
                send_req(OP_START, t + 32'd5, 1'b1, 10'd77);
                send_req(OP_UPDATE, t + 32'd20, 1'b0, 10'd0);
                send_req(OP_UPDATE, t + 32'd40, 1'b1, 10'd0);
                send_req(OP_UPDATE, t + 32'd60, 1'b1, 10'd0);
                send_req(OP_UPDATE, t + 32'd90, 1'b0, 10'd0);
                t = t + 32'd90 + 32'd10001;
                send_req(OP_UPDATE, t, 1'b0, 10'd0);
                send_req(OP_UPDATE, t + 32'd1, 1'b0, 10'd0);
                send_req(OP_ABORT, t + 32'd2, 1'b0, 10'd0);
                send_req(OP_RESET, t + 32'd3, 1'b0, 10'd0);
                send_req(OP_START, t + 32'd4, 1'b0, 10'd1023);
                // A busy arm never times out, even after a long gap.
                send_req(OP_UPDATE, t + 32'd30000, 1'b1, 10'd0);
                send_req(OP_UPDATE, t + 32'd30001, 1'b0, 10'd0);
                send_req(OP_UPDATE, t + 32'd30002, 1'b0, 10'd0);
                send_req(OP_ABORT, t + 32'd30003, 1'b0, 10'd0);
                send_req(OP_START, t + 32'd30004, 1'b1, 10'd49);
                send_req(OP_RESET, t + 32'd30005, 1'b0, 10'd0);
            end
            target = sent + 76;
            while (sent < target) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_req(2'($urandom()), $urandom(), 1'($urandom()),
                                 10'($urandom()));
                    end
                end else begin
                    pick_routine();
                end
            end
        end
        settle();
        $display("Run covered %0d requests under %0d register settings, %0d results compared.",
                 sent, n_settings, checked);
        $display("%0d pick routines ran through to the home pose.", finished_picks);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> pick_place_arm_sequencer.f
rtl/ppas_pkg.sv
rtl/ppas_apb_regs.sv
rtl/ppas_step.sv
rtl/pick_place_arm_sequencer.sv
sim/arm_sequence_checker.sv
sim/testbench.sv
